### sv/mne_pkg.sv
// mesh normal engine package: shared constants, state types and the run descriptor
// no dependencies
`default_nettype none

package mne_pkg;

    localparam int MAX_TRIANGLES_DEF = 16;
    localparam int COORD_BITS_DEF    = 16;
    localparam int LIMIT_W           = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd5;
    localparam int TRI_W             = 5;
    localparam int NORM_W            = 20;
    localparam int UNIT_W            = 16;
    localparam int UNIT_SHIFT        = 15;

    typedef struct packed {
        logic [TRI_W-1:0] tri_cnt;
        logic             ovf;
    } run_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_FETCH,
        B_LOAD,
        B_SCAN,
        B_SM_GO,
        B_SM_WAIT,
        B_FL_GO,
        B_FL_WAIT,
        B_EMIT
    } back_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIVSET,
        N_DIV,
        N_DONE
    } norm_state_t;

endpackage

`default_nettype wire

### sv/mne_ram.sv
// generic simple dual port ram with registered read
// no dependencies
`default_nettype none

module mne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                               clk,
    input  wire                               we,
    input  wire  [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                  wdata,
    input  wire                               re,
    input  wire  [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
    output logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/mne_front.sv
// front end: stores vertices, computes face normals, closes runs
// depends on mne_pkg
`default_nettype none

module mne_front #(
    parameter int MAX_T = mne_pkg::MAX_TRIANGLES_DEF,
    parameter int C     = mne_pkg::COORD_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  acc,
    input  wire  signed [C-1:0]                  x,
    input  wire  signed [C-1:0]                  y,
    input  wire  signed [C-1:0]                  z,
    input  wire                                  mesh_end,
    output logic                                 vwe,
    output logic [$clog2(3*MAX_T)-1:0]           vwaddr,
    output logic [3*C-1:0]                       vwdata,
    output logic                                 fwe,
    output logic [(MAX_T>1?$clog2(MAX_T):1)-1:0] fwaddr,
    output logic [3*(2*C+3)-1:0]                 fwdata,
    output logic                                 push,
    output mne_pkg::run_t                        push_run,
    output logic                                 active
);

    localparam int MAXV  = 3 * MAX_T;
    localparam int VA_W  = $clog2(MAXV);
    localparam int CNT_W = $clog2(MAXV + 1);
    localparam int TA_W  = MAX_T > 1 ? $clog2(MAX_T) : 1;
    localparam int D_W   = C + 1;
    localparam int P_W   = 2 * C + 2;
    localparam int FN_W  = 2 * C + 3;
    localparam int TW    = mne_pkg::TRI_W;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [1:0]            ph_reg, ph_next;
    logic [TW-1:0]         tri_reg, tri_next;
    logic                  ovf_reg, ovf_next;
    logic signed [C-1:0]   v0x_reg, v0y_reg, v0z_reg, v0x_next, v0y_next, v0z_next;
    logic signed [C-1:0]   v1x_reg, v1y_reg, v1z_reg, v1x_next, v1y_next, v1z_next;
    logic signed [D_W-1:0] ax_reg, ay_reg, az_reg, ax_next, ay_next, az_next;
    logic signed [D_W-1:0] bx_reg, by_reg, bz_reg, bx_next, by_next, bz_next;
    logic [1:0]            step_reg, step_next;
    logic [TA_W-1:0]       tw_reg, tw_next;
    logic signed [P_W-1:0] p1_reg, p2_reg, p1_next, p2_next;
    logic                  pv_reg, pv_next;
    logic [1:0]            pc_reg, pc_next;
    logic [TA_W-1:0]       pidx_reg, pidx_next;
    logic signed [FN_W-1:0] fx_reg, fy_reg, fx_next, fy_next;
    logic                  end_reg, end_next;
    mne_pkg::run_t         run_reg, run_next;
    logic signed [FN_W-1:0] val;

    always_comb
    begin
        cnt_next  = cnt_reg;
        ph_next   = ph_reg;
        tri_next  = tri_reg;
        ovf_next  = ovf_reg;
        v0x_next  = v0x_reg;
        v0y_next  = v0y_reg;
        v0z_next  = v0z_reg;
        v1x_next  = v1x_reg;
        v1y_next  = v1y_reg;
        v1z_next  = v1z_reg;
        ax_next   = ax_reg;
        ay_next   = ay_reg;
        az_next   = az_reg;
        bx_next   = bx_reg;
        by_next   = by_reg;
        bz_next   = bz_reg;
        step_next = step_reg;
        tw_next   = tw_reg;
        p1_next   = p1_reg;
        p2_next   = p2_reg;
        pv_next   = 1'b0;
        pc_next   = pc_reg;
        pidx_next = pidx_reg;
        fx_next   = fx_reg;
        fy_next   = fy_reg;
        end_next  = end_reg;
        run_next  = run_reg;
        vwe       = 1'b0;
        vwaddr    = cnt_reg[VA_W-1:0];
        vwdata    = {x, y, z};
        fwe       = 1'b0;
        fwaddr    = pidx_reg;
        val       = FN_W'(p1_reg) - FN_W'(p2_reg);
        fwdata    = {fx_reg, fy_reg, val};
        push      = 1'b0;

        // cross product, one component per cycle
        if (step_reg != 2'd0)
        begin
            pv_next   = 1'b1;
            pc_next   = step_reg - 2'd1;
            pidx_next = tw_reg;
            case (step_reg)
                2'd1:
                begin
                    p1_next = ay_reg * bz_reg;
                    p2_next = az_reg * by_reg;
                end
                2'd2:
                begin
                    p1_next = az_reg * bx_reg;
                    p2_next = ax_reg * bz_reg;
                end
                default:
                begin
                    p1_next = ax_reg * by_reg;
                    p2_next = ay_reg * bx_reg;
                end
            endcase
            step_next = (step_reg == 2'd3) ? 2'd0 : step_reg + 2'd1;
        end

        if (pv_reg)
        begin
            case (pc_reg)
                2'd0:    fx_next = val;
                2'd1:    fy_next = val;
                default: fwe = 1'b1;
            endcase
        end

        if (acc)
        begin
            if (cnt_reg < CNT_W'(MAXV))
            begin
                vwe = 1'b1;
                case (ph_reg)
                    2'd0:
                    begin
                        v0x_next = x;
                        v0y_next = y;
                        v0z_next = z;
                        ph_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        v1x_next = x;
                        v1y_next = y;
                        v1z_next = z;
                        ph_next  = 2'd2;
                    end
                    default:
                    begin
                        ax_next   = D_W'(x) - D_W'(v0x_reg);
                        ay_next   = D_W'(y) - D_W'(v0y_reg);
                        az_next   = D_W'(z) - D_W'(v0z_reg);
                        bx_next   = D_W'(v1x_reg) - D_W'(v0x_reg);
                        by_next   = D_W'(v1y_reg) - D_W'(v0y_reg);
                        bz_next   = D_W'(v1z_reg) - D_W'(v0z_reg);
                        step_next = 2'd1;
                        tw_next   = tri_reg[TA_W-1:0];
                        tri_next  = tri_reg + TW'(1);
                        ph_next   = 2'd0;
                    end
                endcase
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (mesh_end)
            begin
                end_next         = 1'b1;
                run_next.tri_cnt = tri_next;
                run_next.ovf     = ovf_next;
                cnt_next         = '0;
                ph_next          = 2'd0;
                tri_next         = '0;
                ovf_next         = 1'b0;
            end
        end

        // hand the run over once the last face normal is written
        if (end_reg && step_reg == 2'd0 && !pv_reg)
        begin
            push     = 1'b1;
            end_next = 1'b0;
        end
    end

    assign push_run = run_reg;
    assign active   = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ph_reg   <= 2'd0;
            tri_reg  <= '0;
            ovf_reg  <= 1'b0;
            step_reg <= 2'd0;
            pv_reg   <= 1'b0;
            end_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ph_reg   <= ph_next;
            tri_reg  <= tri_next;
            ovf_reg  <= ovf_next;
            step_reg <= step_next;
            pv_reg   <= pv_next;
            end_reg  <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v0x_reg  <= v0x_next;
        v0y_reg  <= v0y_next;
        v0z_reg  <= v0z_next;
        v1x_reg  <= v1x_next;
        v1y_reg  <= v1y_next;
        v1z_reg  <= v1z_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        az_reg   <= az_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        bz_reg   <= bz_next;
        tw_reg   <= tw_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        pc_reg   <= pc_next;
        pidx_reg <= pidx_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        run_reg  <= run_next;
    end

endmodule

`default_nettype wire

### sv/mne_queue.sv
// two entry queue of run descriptors between front and back
// depends on mne_pkg
`default_nettype none

module mne_queue (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  mne_pkg::run_t  push_run,
    input  wire            pop,
    output logic           valid,
    output mne_pkg::run_t  head
);

    mne_pkg::run_t e0_reg, e1_reg, e0_next, e1_next;
    logic [1:0]    cnt_reg, cnt_next;

    always_comb
    begin
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        cnt_next = cnt_reg;
        if (pop && cnt_reg != 2'd0)
        begin
            e0_next  = e1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
        if (push && cnt_reg != 2'd2)
        begin
            if (cnt_next == 2'd0)
            begin
                e0_next = push_run;
            end
            else
            begin
                e1_next = push_run;
            end
            cnt_next = cnt_next + 2'd1;
        end
    end

    assign valid = cnt_reg != 2'd0;
    assign head  = e0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule

`default_nettype wire

### sv/mne_norm.sv
// iterative vector normalizer: scale, sum of squares, integer sqrt, division
// depends on mne_pkg
`default_nettype none

module mne_norm #(
    parameter int SUM_W = 41
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    input  wire  signed [SUM_W-1:0]               in_x,
    input  wire  signed [SUM_W-1:0]               in_y,
    input  wire  signed [SUM_W-1:0]               in_z,
    output logic                                  done,
    output logic signed [mne_pkg::UNIT_W-1:0]     out_x,
    output logic signed [mne_pkg::UNIT_W-1:0]     out_y,
    output logic signed [mne_pkg::UNIT_W-1:0]     out_z
);

    localparam int NW   = mne_pkg::NORM_W;
    localparam int UW   = mne_pkg::UNIT_W;
    localparam int US   = mne_pkg::UNIT_SHIFT;
    localparam int SQ_W = 2 * NW + 2;
    localparam int RT_W = NW + 1;
    localparam int RM_W = NW + 4;
    localparam int DD_W = NW + 2;
    localparam int DR_W = NW + 3;
    localparam int N_W  = NW + US + 1;

    mne_pkg::norm_state_t st_reg, st_next;
    logic [SUM_W-1:0]  m0_reg, m1_reg, m2_reg, m0_next, m1_next, m2_next;
    logic [2:0]        neg_reg, neg_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [1:0]        comp_reg, comp_next;
    logic [2*NW-1:0]   prod_reg, prod_next;
    logic [SQ_W-1:0]   acc_reg, acc_next;
    logic [SQ_W-1:0]   xs_reg, xs_next;
    logic [RT_W-1:0]   root_reg, root_next;
    logic [RM_W-1:0]   rem_reg, rem_next;
    logic [DR_W-1:0]   drem_reg, drem_next;
    logic [15:0]       dnum_reg, dnum_next;
    logic [15:0]       q_reg, q_next;
    logic [UW-1:0]     o0_reg, o1_reg, o2_reg, o0_next, o1_next, o2_next;

    logic [SUM_W-1:0]  mx, msel;
    logic [RM_W-1:0]   rem_sh, trial;
    logic [DR_W-1:0]   rs;
    logic [DD_W-1:0]   dv;
    logic [N_W-1:0]    num;
    logic [15:0]       qf;
    logic [UW-1:0]     sres;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            mne_pkg::N_IDLE:   if (start) st_next = mne_pkg::N_SHIFT;
            mne_pkg::N_SHIFT:
            begin
                if (mx == '0)
                begin
                    st_next = mne_pkg::N_DONE;
                end
                else if (mx < SUM_W'(1) << NW && mx >= SUM_W'(1) << (NW - 1))
                begin
                    st_next = mne_pkg::N_SQ;
                end
            end
            mne_pkg::N_SQ:     if (cnt_reg == 5'd3) st_next = mne_pkg::N_SQRT;
            mne_pkg::N_SQRT:   if (cnt_reg == 5'(RT_W - 1)) st_next = mne_pkg::N_DIVSET;
            mne_pkg::N_DIVSET: st_next = mne_pkg::N_DIV;
            mne_pkg::N_DIV:
            begin
                if (cnt_reg == 5'd15)
                begin
                    st_next = (comp_reg == 2'd2) ? mne_pkg::N_DONE : mne_pkg::N_DIVSET;
                end
            end
            mne_pkg::N_DONE:   st_next = mne_pkg::N_IDLE;
            default:           st_next = mne_pkg::N_IDLE;
        endcase
    end

    always_comb
    begin
        m0_next   = m0_reg;
        m1_next   = m1_reg;
        m2_next   = m2_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg + 5'd1;
        comp_next = comp_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        xs_next   = xs_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        drem_next = drem_reg;
        dnum_next = dnum_reg;
        q_next    = q_reg;
        o0_next   = o0_reg;
        o1_next   = o1_reg;
        o2_next   = o2_reg;
        done      = 1'b0;

        mx = (m0_reg > m1_reg) ? m0_reg : m1_reg;
        mx = (m2_reg > mx) ? m2_reg : mx;
        case (comp_reg)
            2'd0:    msel = m0_reg;
            2'd1:    msel = m1_reg;
            default: msel = m2_reg;
        endcase
        rem_sh = {rem_reg[RM_W-3:0], xs_reg[SQ_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        trial  = RM_W'(trial);
        num    = {msel[NW-1:0], {US{1'b0}}} + N_W'(root_reg);
        dv     = {root_reg, 1'b0};
        rs     = {drem_reg[DR_W-2:0], dnum_reg[15]};
        qf     = {q_reg[14:0], rs >= DR_W'(dv)};
        sres   = neg_reg[comp_reg] ? UW'(-qf) : UW'(qf);

        unique case (st_reg)
            mne_pkg::N_IDLE:
            begin
                neg_next = {in_z[SUM_W-1], in_y[SUM_W-1], in_x[SUM_W-1]};
                m0_next  = in_x[SUM_W-1] ? SUM_W'(-in_x) : SUM_W'(in_x);
                m1_next  = in_y[SUM_W-1] ? SUM_W'(-in_y) : SUM_W'(in_y);
                m2_next  = in_z[SUM_W-1] ? SUM_W'(-in_z) : SUM_W'(in_z);
            end
            mne_pkg::N_SHIFT:
            begin
                cnt_next = 5'd0;
                acc_next = '0;
                if (mx == '0)
                begin
                    o0_next = '0;
                    o1_next = '0;
                    o2_next = '0;
                end
                else if (mx >= SUM_W'(1) << NW)
                begin
                    m0_next = m0_reg >> 1;
                    m1_next = m1_reg >> 1;
                    m2_next = m2_reg >> 1;
                end
                else if (mx < SUM_W'(1) << (NW - 1))
                begin
                    m0_next = m0_reg << 1;
                    m1_next = m1_reg << 1;
                    m2_next = m2_reg << 1;
                end
            end
            mne_pkg::N_SQ:
            begin
                case (cnt_reg[1:0])
                    2'd0:    prod_next = m0_reg[NW-1:0] * m0_reg[NW-1:0];
                    2'd1:    prod_next = m1_reg[NW-1:0] * m1_reg[NW-1:0];
                    default: prod_next = m2_reg[NW-1:0] * m2_reg[NW-1:0];
                endcase
                if (cnt_reg != 5'd0)
                begin
                    acc_next = acc_reg + SQ_W'(prod_reg);
                end
                if (cnt_reg == 5'd3)
                begin
                    xs_next   = acc_reg + SQ_W'(prod_reg);
                    root_next = '0;
                    rem_next  = '0;
                    cnt_next  = 5'd0;
                end
            end
            mne_pkg::N_SQRT:
            begin
                xs_next = xs_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[RT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[RT_W-2:0], 1'b0};
                end
                if (cnt_reg == 5'(RT_W - 1))
                begin
                    comp_next = 2'd0;
                end
            end
            mne_pkg::N_DIVSET:
            begin
                drem_next = DR_W'(num[N_W-1:16]);
                dnum_next = num[15:0];
                q_next    = '0;
                cnt_next  = 5'd0;
            end
            mne_pkg::N_DIV:
            begin
                drem_next = (rs >= DR_W'(dv)) ? rs - DR_W'(dv) : rs;
                dnum_next = dnum_reg << 1;
                q_next    = qf;
                if (cnt_reg == 5'd15)
                begin
                    case (comp_reg)
                        2'd0:    o0_next = sres;
                        2'd1:    o1_next = sres;
                        default: o2_next = sres;
                    endcase
                    comp_next = comp_reg + 2'd1;
                end
            end
            mne_pkg::N_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign out_x = o0_reg;
    assign out_y = o1_reg;
    assign out_z = o2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= mne_pkg::N_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m0_reg   <= m0_next;
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        comp_reg <= comp_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        xs_reg   <= xs_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        drem_reg <= drem_next;
        dnum_reg <= dnum_next;
        q_reg    <= q_next;
        o0_reg   <= o0_next;
        o1_reg   <= o1_next;
        o2_reg   <= o2_next;
    end

endmodule

`default_nettype wire

### sv/mne_back.sv
// back end: per vertex scan for equal positions, normalization and result request
// depends on mne_pkg and mne_norm
`default_nettype none

module mne_back #(
    parameter int MAX_T = mne_pkg::MAX_TRIANGLES_DEF,
    parameter int C     = mne_pkg::COORD_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  run_valid,
    input  mne_pkg::run_t                        run,
    input  wire  [mne_pkg::LIMIT_W-1:0]          match_limit,
    output logic                                 pop,
    output logic                                 active,
    output logic                                 vre,
    output logic [$clog2(3*MAX_T)-1:0]           vraddr,
    input  wire  [3*C-1:0]                       vrdata,
    output logic                                 fre,
    output logic [(MAX_T>1?$clog2(MAX_T):1)-1:0] fraddr,
    input  wire  [3*(2*C+3)-1:0]                 frdata,
    output logic                                 result_valid,
    output logic [$clog2(3*MAX_T)-1:0]           vertex_index,
    output logic signed [mne_pkg::UNIT_W-1:0]    smooth_nx,
    output logic signed [mne_pkg::UNIT_W-1:0]    smooth_ny,
    output logic signed [mne_pkg::UNIT_W-1:0]    smooth_nz,
    output logic signed [mne_pkg::UNIT_W-1:0]    flat_nx,
    output logic signed [mne_pkg::UNIT_W-1:0]    flat_ny,
    output logic signed [mne_pkg::UNIT_W-1:0]    flat_nz,
    output logic                                 overflowed,
    output logic                                 last_result
);

    localparam int MAXV  = 3 * MAX_T;
    localparam int VA_W  = $clog2(MAXV);
    localparam int CNT_W = $clog2(MAXV + 1);
    localparam int TA_W  = MAX_T > 1 ? $clog2(MAX_T) : 1;
    localparam int FN_W  = 2 * C + 3;
    localparam int SUM_W = FN_W + $clog2(MAXV);
    localparam int LW    = mne_pkg::LIMIT_W;
    localparam int UW    = mne_pkg::UNIT_W;

    mne_pkg::back_state_t st_reg, st_next;
    logic [CNT_W-1:0]  n_reg, n_next, i_reg, i_next, j_reg, j_next;
    logic [TA_W-1:0]   it_reg, it_next, jt_reg, jt_next;
    logic [1:0]        im_reg, im_next, jm_reg, jm_next;
    logic              ovf_reg, ovf_next;
    logic [3*C-1:0]    own_reg, own_next;
    logic [3*FN_W-1:0] flat_reg, flat_next;
    logic              pend_reg, pend_next;
    logic [LW-1:0]     inst_reg, inst_next;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg, sx_next, sy_next, sz_next;
    logic [UW-1:0]     smx_reg, smy_reg, smz_reg, smx_next, smy_next, smz_next;
    logic [UW-1:0]     flx_reg, fly_reg, flz_reg, flx_next, fly_next, flz_next;
    logic              rv_reg, rv_next, last_reg, last_next, ovo_reg, ovo_next;
    logic [VA_W-1:0]   idx_reg, idx_next;

    logic                    nstart, ndone;
    logic signed [SUM_W-1:0] nx, ny, nz;
    logic signed [UW-1:0]    ox, oy, oz;
    logic signed [FN_W-1:0]  fjx, fjy, fjz, fox, foy, foz;
    logic [CNT_W-1:0]        run_n;

    assign fjx   = frdata[3*FN_W-1 -: FN_W];
    assign fjy   = frdata[2*FN_W-1 -: FN_W];
    assign fjz   = frdata[FN_W-1:0];
    assign fox   = flat_reg[3*FN_W-1 -: FN_W];
    assign foy   = flat_reg[2*FN_W-1 -: FN_W];
    assign foz   = flat_reg[FN_W-1:0];
    assign run_n = CNT_W'(run.tri_cnt) * CNT_W'(3);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            mne_pkg::B_IDLE:    if (run_valid && run_n != '0) st_next = mne_pkg::B_FETCH;
            mne_pkg::B_FETCH:   st_next = mne_pkg::B_LOAD;
            mne_pkg::B_LOAD:    st_next = mne_pkg::B_SCAN;
            mne_pkg::B_SCAN:    if (j_reg == n_reg) st_next = mne_pkg::B_SM_GO;
            mne_pkg::B_SM_GO:   st_next = mne_pkg::B_SM_WAIT;
            mne_pkg::B_SM_WAIT: if (ndone) st_next = mne_pkg::B_FL_GO;
            mne_pkg::B_FL_GO:   st_next = mne_pkg::B_FL_WAIT;
            mne_pkg::B_FL_WAIT: if (ndone) st_next = mne_pkg::B_EMIT;
            mne_pkg::B_EMIT:
            begin
                st_next = (i_reg + CNT_W'(1) == n_reg) ? mne_pkg::B_IDLE : mne_pkg::B_FETCH;
            end
            default:            st_next = mne_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        n_next    = n_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        it_next   = it_reg;
        jt_next   = jt_reg;
        im_next   = im_reg;
        jm_next   = jm_reg;
        ovf_next  = ovf_reg;
        own_next  = own_reg;
        flat_next = flat_reg;
        pend_next = 1'b0;
        inst_next = inst_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        sz_next   = sz_reg;
        smx_next  = smx_reg;
        smy_next  = smy_reg;
        smz_next  = smz_reg;
        flx_next  = flx_reg;
        fly_next  = fly_reg;
        flz_next  = flz_reg;
        rv_next   = 1'b0;
        last_next = last_reg;
        ovo_next  = ovo_reg;
        idx_next  = idx_reg;
        pop       = 1'b0;
        vre       = 1'b0;
        vraddr    = i_reg[VA_W-1:0];
        fre       = 1'b0;
        fraddr    = it_reg;
        nstart    = 1'b0;
        nx        = sx_reg;
        ny        = sy_reg;
        nz        = sz_reg;

        unique case (st_reg)
            mne_pkg::B_IDLE:
            begin
                if (run_valid)
                begin
                    pop      = 1'b1;
                    n_next   = run_n;
                    ovf_next = run.ovf;
                    i_next   = '0;
                    it_next  = '0;
                    im_next  = 2'd0;
                end
            end
            mne_pkg::B_FETCH:
            begin
                vre = 1'b1;
                fre = 1'b1;
            end
            mne_pkg::B_LOAD:
            begin
                own_next  = vrdata;
                flat_next = frdata;
                j_next    = '0;
                jt_next   = '0;
                jm_next   = 2'd0;
                inst_next = '0;
                sx_next   = '0;
                sy_next   = '0;
                sz_next   = '0;
            end
            mne_pkg::B_SCAN:
            begin
                vraddr = j_reg[VA_W-1:0];
                fraddr = jt_reg;
                if (j_reg != n_reg)
                begin
                    vre       = 1'b1;
                    fre       = 1'b1;
                    pend_next = 1'b1;
                    j_next    = j_reg + CNT_W'(1);
                    if (jm_reg == 2'd2)
                    begin
                        jm_next = 2'd0;
                        jt_next = jt_reg + TA_W'(1);
                    end
                    else
                    begin
                        jm_next = jm_reg + 2'd1;
                    end
                end
                if (pend_reg && vrdata == own_reg && inst_reg < match_limit)
                begin
                    sx_next   = sx_reg + SUM_W'(fjx);
                    sy_next   = sy_reg + SUM_W'(fjy);
                    sz_next   = sz_reg + SUM_W'(fjz);
                    inst_next = inst_reg + LW'(1);
                end
            end
            mne_pkg::B_SM_GO:
            begin
                nstart = 1'b1;
            end
            mne_pkg::B_SM_WAIT:
            begin
                if (ndone)
                begin
                    smx_next = ox;
                    smy_next = oy;
                    smz_next = oz;
                end
            end
            mne_pkg::B_FL_GO:
            begin
                nstart = 1'b1;
                nx     = SUM_W'(fox);
                ny     = SUM_W'(foy);
                nz     = SUM_W'(foz);
            end
            mne_pkg::B_FL_WAIT:
            begin
                if (ndone)
                begin
                    flx_next = ox;
                    fly_next = oy;
                    flz_next = oz;
                end
            end
            mne_pkg::B_EMIT:
            begin
                rv_next   = 1'b1;
                idx_next  = i_reg[VA_W-1:0];
                ovo_next  = ovf_reg;
                last_next = (i_reg + CNT_W'(1) == n_reg);
                i_next    = i_reg + CNT_W'(1);
                if (im_reg == 2'd2)
                begin
                    im_next = 2'd0;
                    it_next = it_reg + TA_W'(1);
                end
                else
                begin
                    im_next = im_reg + 2'd1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    mne_norm #(
        .SUM_W (SUM_W)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (nstart),
        .in_x  (nx),
        .in_y  (ny),
        .in_z  (nz),
        .done  (ndone),
        .out_x (ox),
        .out_y (oy),
        .out_z (oz)
    );

    assign active       = st_reg != mne_pkg::B_IDLE;
    assign result_valid = rv_reg;
    assign vertex_index = idx_reg;
    assign smooth_nx    = smx_reg;
    assign smooth_ny    = smy_reg;
    assign smooth_nz    = smz_reg;
    assign flat_nx      = flx_reg;
    assign flat_ny      = fly_reg;
    assign flat_nz      = flz_reg;
    assign overflowed   = ovo_reg;
    assign last_result  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= mne_pkg::B_IDLE;
            rv_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            rv_reg   <= rv_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        it_reg   <= it_next;
        jt_reg   <= jt_next;
        im_reg   <= im_next;
        jm_reg   <= jm_next;
        ovf_reg  <= ovf_next;
        own_reg  <= own_next;
        flat_reg <= flat_next;
        inst_reg <= inst_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        sz_reg   <= sz_next;
        smx_reg  <= smx_next;
        smy_reg  <= smy_next;
        smz_reg  <= smz_next;
        flx_reg  <= flx_next;
        fly_reg  <= fly_next;
        flz_reg  <= flz_next;
        last_reg <= last_next;
        ovo_reg  <= ovo_next;
        idx_reg  <= idx_next;
    end

endmodule

`default_nettype wire

### sv/mesh_normal_engine_unit.sv
// mesh normal engine top level: config register, vertex and face normal rams,
// front end, run queue and back end; depends on mne_pkg and all mne_ modules
//
// usage: vertices are requested with start while busy is low, one per cycle,
// three per triangle; the request with mesh_end high closes the mesh. while
// loading, a vertex is taken every cycle. after mesh_end, busy stays high until
// the last result has gone out. per emitted vertex the back end scans all n
// stored vertices and runs the normalizer twice; each pass scales the vector,
// sums the squares, takes an integer square root and divides each of the three
// components by the root. results come out in load order, each on the result ports
// for one cycle with result_valid high; the receiver cannot stall. an unfinished
// last triangle gives no results, an empty mesh gives none. vertices beyond
// capacity are dropped and overflowed is set on every result of that mesh.
// match_limit must be written through cfg_we and cfg_wdata only while idle;
// the block itself does not enforce this. reset clears all control state and
// sets match_limit to 5; the rams need no clearing.
`default_nettype none

module mesh_normal_engine_unit #(
    parameter int MAX_TRIANGLES = mne_pkg::MAX_TRIANGLES_DEF,
    parameter int COORD_BITS    = mne_pkg::COORD_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 cfg_we,
    input  wire  [mne_pkg::LIMIT_W-1:0]         cfg_wdata,
    input  wire  signed [COORD_BITS-1:0]        vertex_x,
    input  wire  signed [COORD_BITS-1:0]        vertex_y,
    input  wire  signed [COORD_BITS-1:0]        vertex_z,
    input  wire                                 mesh_end,
    output logic                                result_valid,
    output logic [$clog2(3*MAX_TRIANGLES)-1:0]  vertex_index,
    output logic signed [mne_pkg::UNIT_W-1:0]   smooth_nx,
    output logic signed [mne_pkg::UNIT_W-1:0]   smooth_ny,
    output logic signed [mne_pkg::UNIT_W-1:0]   smooth_nz,
    output logic signed [mne_pkg::UNIT_W-1:0]   flat_nx,
    output logic signed [mne_pkg::UNIT_W-1:0]   flat_ny,
    output logic signed [mne_pkg::UNIT_W-1:0]   flat_nz,
    output logic                                overflowed,
    output logic                                last_result
);

    localparam int MAXV = 3 * MAX_TRIANGLES;
    localparam int VA_W = $clog2(MAXV);
    localparam int TA_W = MAX_TRIANGLES > 1 ? $clog2(MAX_TRIANGLES) : 1;
    localparam int FN_W = 2 * COORD_BITS + 3;

    logic [mne_pkg::LIMIT_W-1:0] limit_reg;
    logic                  acc;
    logic                  vwe, vre, fwe, fre;
    logic [VA_W-1:0]       vwaddr, vraddr;
    logic [TA_W-1:0]       fwaddr, fraddr;
    logic [3*COORD_BITS-1:0] vwdata, vrdata;
    logic [3*FN_W-1:0]     fwdata, frdata;
    logic                  push, pop, q_valid, front_active, back_active;
    mne_pkg::run_t         push_run, head;

    assign busy = front_active | q_valid | back_active;
    assign acc  = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= mne_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    mne_ram #(
        .WIDTH (3 * COORD_BITS),
        .DEPTH (MAXV)
    ) u_vram (
        .clk   (clk),
        .we    (vwe),
        .waddr (vwaddr),
        .wdata (vwdata),
        .re    (vre),
        .raddr (vraddr),
        .rdata (vrdata)
    );

    mne_ram #(
        .WIDTH (3 * FN_W),
        .DEPTH (MAX_TRIANGLES)
    ) u_fram (
        .clk   (clk),
        .we    (fwe),
        .waddr (fwaddr),
        .wdata (fwdata),
        .re    (fre),
        .raddr (fraddr),
        .rdata (frdata)
    );

    mne_front #(
        .MAX_T (MAX_TRIANGLES),
        .C     (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .x        (vertex_x),
        .y        (vertex_y),
        .z        (vertex_z),
        .mesh_end (mesh_end),
        .vwe      (vwe),
        .vwaddr   (vwaddr),
        .vwdata   (vwdata),
        .fwe      (fwe),
        .fwaddr   (fwaddr),
        .fwdata   (fwdata),
        .push     (push),
        .push_run (push_run),
        .active   (front_active)
    );

    mne_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .valid    (q_valid),
        .head     (head)
    );

    mne_back #(
        .MAX_T (MAX_TRIANGLES),
        .C     (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .run_valid    (q_valid),
        .run          (head),
        .match_limit  (limit_reg),
        .pop          (pop),
        .active       (back_active),
        .vre          (vre),
        .vraddr       (vraddr),
        .vrdata       (vrdata),
        .fre          (fre),
        .fraddr       (fraddr),
        .frdata       (frdata),
        .result_valid (result_valid),
        .vertex_index (vertex_index),
        .smooth_nx    (smooth_nx),
        .smooth_ny    (smooth_ny),
        .smooth_nz    (smooth_nz),
        .flat_nx      (flat_nx),
        .flat_ny      (flat_ny),
        .flat_nz      (flat_nz),
        .overflowed   (overflowed),
        .last_result  (last_result)
    );

endmodule

`default_nettype wire

### test/tb.sv
// testbench for mesh_normal_engine_unit: streams meshes of vertices and checks every
// smoothed and flat normal against a scoreboard with its own normal predictor
// depends on mne_pkg and the mesh_normal_engine_unit rtl
`timescale 1ns / 100ps

typedef struct packed {
    logic [5:0]  idx;
    logic [15:0] sx, sy, sz, fx, fy, fz;
    logic        ovf, last;
} normal_rec_t;

class normal_scoreboard;
    localparam int MAX_VERTS = 3 * mne_pkg::MAX_TRIANGLES_DEF;
    longint vx[MAX_VERTS], vy[MAX_VERTS], vz[MAX_VERTS];
    longint fnx[mne_pkg::MAX_TRIANGLES_DEF], fny[mne_pkg::MAX_TRIANGLES_DEF];
    longint fnz[mne_pkg::MAX_TRIANGLES_DEF];
    int count;
    bit overflow;
    bit [5:0] limit;
    normal_rec_t pending[$];
    int errors, checked, meshes;

    function new();
        count = 0;
        overflow = 0;
        limit = mne_pkg::LIMIT_RESET;
        errors = 0;
        checked = 0;
        meshes = 0;
    endfunction

    function void to_unit(input longint ax, ay, az, output logic [15:0] ox, oy, oz);
        longint a[3];
        longint unsigned mag[3], mx, sum, len, q, x, r, b;
        logic [15:0] o[3];
        int p;
        a[0] = ax; a[1] = ay; a[2] = az;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = a[i] < 0 ? -a[i] : a[i];
            if (mag[i] > mx)
                mx = mag[i];
        end
        if (mx == 0)
        begin
            ox = 0; oy = 0; oz = 0;
            return;
        end
        p = 0;
        while ((mx >> p) > 1)
            p++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (p > 19)
                mag[i] = mag[i] >> (p - 19);
            else
                mag[i] = mag[i] << (19 - p);
            sum += mag[i] * mag[i];
        end
        // integer square root, floor
        x = sum;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        len = r;
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] * 32768 + len) / (2 * len);
            o[i] = a[i] < 0 ? 16'(-q) : 16'(q);
        end
        ox = o[0]; oy = o[1]; oz = o[2];
    endfunction

    function void note_request(logic signed [15:0] x, y, z, logic last_vertex);
        int k, bb, t, n, hits;
        longint ax, ay, az, bx, by, bz, s0, s1, s2;
        normal_rec_t rec;
        if (count < MAX_VERTS)
        begin
            k = count;
            vx[k] = x; vy[k] = y; vz[k] = z;
            if (k % 3 == 2)
            begin
                bb = k - 2;
                t = k / 3;
                ax = vx[bb+2] - vx[bb]; ay = vy[bb+2] - vy[bb]; az = vz[bb+2] - vz[bb];
                bx = vx[bb+1] - vx[bb]; by = vy[bb+1] - vy[bb]; bz = vz[bb+1] - vz[bb];
                fnx[t] = ay * bz - az * by;
                fny[t] = az * bx - ax * bz;
                fnz[t] = ax * by - ay * bx;
            end
            count = k + 1;
        end
        else
            overflow = 1;
        if (!last_vertex)
            return;
        meshes++;
        n = (count / 3) * 3;
        for (int i = 0; i < n; i++)
        begin
            s0 = 0; s1 = 0; s2 = 0;
            hits = 0;
            for (int j = 0; j < n && hits < limit; j++)
                if (vx[j] == vx[i] && vy[j] == vy[i] && vz[j] == vz[i])
                begin
                    s0 += fnx[j/3]; s1 += fny[j/3]; s2 += fnz[j/3];
                    hits++;
                end
            rec.idx = i;
            to_unit(s0, s1, s2, rec.sx, rec.sy, rec.sz);
            to_unit(fnx[i/3], fny[i/3], fnz[i/3], rec.fx, rec.fy, rec.fz);
            rec.ovf = overflow;
            rec.last = (i + 1 == n);
            pending.push_back(rec);
        end
        count = 0;
        overflow = 0;
    endfunction

    function void diff(string name, longint e, longint a);
        if (e != a)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
            errors++;
        end
    endfunction

    function void check_result(normal_rec_t act);
        normal_rec_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result, expected none actual index %0d",
                     $time, act.idx);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        diff("vertex_index", e.idx, act.idx);
        diff("smooth_nx", $signed(e.sx), $signed(act.sx));
        diff("smooth_ny", $signed(e.sy), $signed(act.sy));
        diff("smooth_nz", $signed(e.sz), $signed(act.sz));
        diff("flat_nx", $signed(e.fx), $signed(act.fx));
        diff("flat_ny", $signed(e.fy), $signed(act.fy));
        diff("flat_nz", $signed(e.fz), $signed(act.fz));
        diff("overflowed", e.ovf, act.ovf);
        diff("last_result", e.last, act.last);
    endfunction
endclass

module tb;
    logic clk, rst_n, start, cfg_we, mesh_end;
    logic [mne_pkg::LIMIT_W-1:0] cfg_wdata;
    logic signed [15:0] vertex_x, vertex_y, vertex_z;
    logic busy, result_valid, overflowed, last_result;
    logic [5:0] vertex_index;
    logic signed [15:0] smooth_nx, smooth_ny, smooth_nz, flat_nx, flat_ny, flat_nz;

    normal_scoreboard sb;
    int idle_pct;
    int sent;
    logic signed [15:0] pool_x[8], pool_y[8], pool_z[8];

    mesh_normal_engine_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
        .mesh_end(mesh_end), .result_valid(result_valid), .vertex_index(vertex_index),
        .smooth_nx(smooth_nx), .smooth_ny(smooth_ny), .smooth_nz(smooth_nz),
        .flat_nx(flat_nx), .flat_ny(flat_ny), .flat_nz(flat_nz),
        .overflowed(overflowed), .last_result(last_result)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && result_valid)
            sb.check_result('{vertex_index, smooth_nx, smooth_ny, smooth_nz,
                              flat_nx, flat_ny, flat_nz, overflowed, last_result});

    task automatic send_vertex(logic signed [15:0] x, y, z, logic e);
        start <= 1'b1;
        vertex_x <= x;
        vertex_y <= y;
        vertex_z <= z;
        mesh_end <= e;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(x, y, z, e);
        sent++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic write_limit(logic [5:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.limit = v;
    endtask

    function automatic logic signed [15:0] rand_coord();
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic random_mesh(int nverts);
        int pool_n, sel;
        logic signed [15:0] x, y, z;
        pool_n = $urandom_range(2, 8);
        for (int i = 0; i < pool_n; i++)
        begin
            pool_x[i] = rand_coord();
            pool_y[i] = rand_coord();
            pool_z[i] = rand_coord();
        end
        for (int i = 0; i < nverts; i++)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                sel = $urandom_range(0, pool_n - 1);
                x = pool_x[sel]; y = pool_y[sel]; z = pool_z[sel];
            end
            else
            begin
                x = rand_coord(); y = rand_coord(); z = rand_coord();
            end
            send_vertex(x, y, z, i == nverts - 1);
        end
    endtask

    initial
    begin
        int r, nv;
        logic [5:0] lim;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        vertex_x = '0;
        vertex_y = '0;
        vertex_z = '0;
        mesh_end = 1'b0;
        idle_pct = 0;
        sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, shared corners, degenerate, empty and incomplete meshes
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_vertex(16'sh7fff, 16'sh8000, 16'sh8000, 0);
        send_vertex(16'sh8000, 16'sh7fff, 16'sh7fff, 0);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_vertex(16'sh8000, 16'sh7fff, 16'sh8000, 0);
        send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send_vertex(16'sh0100, 16'sh0100, 16'sh0100, 0);
        send_vertex(16'sh0100, 16'sh0100, 16'sh0100, 0);
        send_vertex(16'sh0100, 16'sh0100, 16'sh0100, 1);
        send_vertex(16'sh1234, 16'sh0000, 16'shffff, 1);
        send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 0);
        send_vertex(16'sh0001, 16'sh0000, 16'sh0000, 0);
        send_vertex(16'sh0000, 16'sh0001, 16'sh0000, 0);
        send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1);
        write_limit(6'd0);
        random_mesh(6);
        write_limit(6'd63);
        random_mesh(9);

        r = 0;
        while (sent < 470)
        begin
            if (r % 4 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: lim = 6'd1;
                    1: lim = 6'd48;
                    2: lim = 6'd0;
                    3: lim = mne_pkg::LIMIT_RESET;
                    default: lim = 6'($urandom_range(0, 63));
                endcase
                write_limit(lim);
                case ((r / 4) % 3)
                    0: idle_pct = 0;
                    1: idle_pct = 79;
                    default: idle_pct = 37;
                endcase
            end
            sel_size: begin
                int d;
                d = $urandom_range(0, 99);
                if (d < 78)
                    nv = 3 * $urandom_range(1, 6);
                else if (d < 88)
                    nv = 3 * $urandom_range(0, 5) + $urandom_range(1, 2);
                else if (d < 94)
                    nv = 48;
                else
                    nv = $urandom_range(49, 53);
            end
            random_mesh(nv);
            r++;
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("sent %0d vertices in %0d meshes, checked %0d normal results",
                 sent, sb.meshes, sb.checked);
        $display("match limits 0, 1, 5, 48, 63 and random; idle levels 0, 37, 79 percent");
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
